[design/slcfr_pkg.sv]
// Shared types and constants for the sync/length/checksum frame receiver
`default_nettype none
package slcfr_pkg;

    localparam int BUFFER_BYTES = 64;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int LEN_W        = 7;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [7:0] SYNC_FIRST  = 8'hA0;
    localparam logic [7:0] SYNC_SECOND = 8'hA1;
    localparam logic [7:0] GOOD_SUM    = 8'hFF;

    typedef enum logic [1:0] {
        ST_GOOD = 2'd0,
        ST_CSUM = 2'd1,
        ST_LEN  = 2'd2
    } status_t;

    typedef struct packed {
        status_t            status;
        logic [LEN_W-1:0]   count;
    } job_t;

    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [7:0]         data;
    } store_wr_t;

endpackage
`default_nettype wire

[design/slcfr_if.sv]
// Handshake channel interfaces for received bytes and replayed frame words
`default_nettype none
interface slcfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slcfr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] data_byte;
    logic [5:0] byte_index;
    logic       last;

    modport source (output valid, output status, output data_byte, output byte_index,
                    output last, input ready);
    modport sink   (input valid, input status, input data_byte, input byte_index,
                    input last, output ready);
endinterface
`default_nettype wire

[design/sync_length_checksum_frame_receiver.sv]
// Top level of the sync/length/checksum frame receiver
//
//  channel   dir  handshake       payload
//  in_ch     in   valid/ready     rx_byte[7:0]
//  out_ch    out  valid/ready     status[1:0] data_byte[7:0] byte_index[5:0] last
//  cfg       in   cfg_wr_en       cfg_wr_data[6:0] (max_length)
//
//  A received byte is accepted while the job queue has room; a full queue stalls it.
//  A good frame replays from the store word by word: a store read state, then a send state that waits for ready.
//  Error frames give one word; a two-entry job queue separates parsing from replay.
//  Payload bytes of the next frame wait while a good frame is still replaying.
//  Reset is immediate; the store needs no clearing pass.
`default_nettype none
module sync_length_checksum_frame_receiver
    import slcfr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [LEN_W-1:0]   cfg_wr_data,
    slcfr_in_if.sink                in_ch,
    slcfr_out_if.source             out_ch
);

    logic       queue_full;
    logic       queue_push;
    job_t       push_job;
    job_t       head_job;
    logic       queue_not_empty;
    logic       queue_pop;
    store_wr_t  store_wr;
    logic       replay_done;

    slcfr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .queue_full  (queue_full),
        .queue_push  (queue_push),
        .queue_job   (push_job),
        .store_wr    (store_wr),
        .replay_done (replay_done)
    );

    slcfr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (queue_push),
        .push_job  (push_job),
        .full      (queue_full),
        .pop       (queue_pop),
        .head_job  (head_job),
        .not_empty (queue_not_empty)
    );

    slcfr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .store_wr    (store_wr),
        .job_valid   (queue_not_empty),
        .job         (head_job),
        .job_pop     (queue_pop),
        .replay_done (replay_done),
        .out_ch      (out_ch)
    );

endmodule
`default_nettype wire

[design/slcfr_front.sv]
// Front end: sync hunt, length check, payload store writes and checksum
`default_nettype none
module slcfr_front
    import slcfr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [LEN_W-1:0]   cfg_wr_data,
    slcfr_in_if.sink                in_ch,
    input  wire logic               queue_full,
    output logic                    queue_push,
    output job_t                    queue_job,
    output store_wr_t               store_wr,
    input  wire logic               replay_done
);

    logic               sync_stage_reg;
    logic               in_frame_reg;
    logic [LEN_W-1:0]   byte_pos_reg;
    logic [LEN_W-1:0]   frame_len_reg;
    logic [7:0]         sum_reg;
    logic [LEN_W-1:0]   max_len_reg;
    logic               good_pend_reg;

    logic               accept;
    logic               payload_byte;
    logic [LEN_W-1:0]   limit;
    logic [7:0]         sum_next;
    logic               frame_end;
    logic               hi_bad;
    logic               lo_bad;

    assign limit = (max_len_reg > LEN_W'(BUFFER_BYTES)) ? LEN_W'(BUFFER_BYTES) : max_len_reg;

    assign payload_byte = in_frame_reg && (byte_pos_reg >= LEN_W'(2));
    assign in_ch.ready  = !queue_full && !(payload_byte && good_pend_reg);
    assign accept       = in_ch.valid && in_ch.ready;

    assign sum_next  = sum_reg + in_ch.rx_byte;
    assign frame_end = byte_pos_reg >= (frame_len_reg + LEN_W'(1));
    assign hi_bad    = in_ch.rx_byte != 8'd0;
    assign lo_bad    = (in_ch.rx_byte == 8'd0) || (in_ch.rx_byte > {1'b0, limit});

    always_comb
    begin
        queue_push       = 1'b0;
        queue_job.status = ST_LEN;
        queue_job.count  = frame_len_reg;
        if (accept && in_frame_reg)
        begin
            if (byte_pos_reg == LEN_W'(0))
            begin
                queue_push = hi_bad;
            end
            else if (byte_pos_reg == LEN_W'(1))
            begin
                queue_push = lo_bad;
            end
            else
            begin
                queue_push       = frame_end;
                queue_job.status = (sum_next == GOOD_SUM) ? ST_GOOD : ST_CSUM;
            end
        end
    end

    assign store_wr.en   = accept && payload_byte;
    assign store_wr.addr = ADDR_W'(byte_pos_reg - LEN_W'(2));
    assign store_wr.data = in_ch.rx_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_stage_reg <= 1'b0;
            in_frame_reg   <= 1'b0;
            byte_pos_reg   <= '0;
            frame_len_reg  <= '0;
            sum_reg        <= '0;
            max_len_reg    <= LEN_W'(BUFFER_BYTES);
            good_pend_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_len_reg <= cfg_wr_data;
            end
            if (replay_done)
            begin
                good_pend_reg <= 1'b0;
            end
            if (accept)
            begin
                if (!in_frame_reg)
                begin
                    if (!sync_stage_reg && in_ch.rx_byte == SYNC_FIRST)
                    begin
                        sync_stage_reg <= 1'b1;
                    end
                    else if (sync_stage_reg && in_ch.rx_byte == SYNC_SECOND)
                    begin
                        sync_stage_reg <= 1'b0;
                        in_frame_reg   <= 1'b1;
                        byte_pos_reg   <= '0;
                        frame_len_reg  <= '0;
                        sum_reg        <= '0;
                    end
                    else
                    begin
                        sync_stage_reg <= 1'b0;
                    end
                end
                else if (byte_pos_reg == LEN_W'(0))
                begin
                    if (hi_bad)
                    begin
                        in_frame_reg <= 1'b0;
                    end
                    else
                    begin
                        byte_pos_reg <= LEN_W'(1);
                    end
                end
                else if (byte_pos_reg == LEN_W'(1))
                begin
                    if (lo_bad)
                    begin
                        in_frame_reg <= 1'b0;
                        byte_pos_reg <= '0;
                    end
                    else
                    begin
                        frame_len_reg <= in_ch.rx_byte[LEN_W-1:0];
                        byte_pos_reg  <= LEN_W'(2);
                        sum_reg       <= '0;
                    end
                end
                else
                begin
                    sum_reg <= sum_next;
                    if (frame_end)
                    begin
                        in_frame_reg <= 1'b0;
                        byte_pos_reg <= '0;
                        if (sum_next == GOOD_SUM)
                        begin
                            good_pend_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        byte_pos_reg <= byte_pos_reg + LEN_W'(1);
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

[design/slcfr_queue.sv]
// Short job queue between the front end and the replay engine
`default_nettype none
module slcfr_queue
    import slcfr_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  job_t        push_job,
    output logic        full,
    input  wire logic   pop,
    output job_t        head_job,
    output logic        not_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t               slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    logic               do_push;
    logic               do_pop;

    assign full      = count_reg == CNT_W'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head_job  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

[design/slcfr_back.sv]
// Back end: payload store and replay of frames and error words
`default_nettype none
module slcfr_back
    import slcfr_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  store_wr_t   store_wr,
    input  wire logic   job_valid,
    input  job_t        job,
    output logic        job_pop,
    output logic        replay_done,
    slcfr_out_if.source out_ch
);

    typedef enum logic [1:0] {
        IDLE,
        READ,
        SEND
    } state_t;

    state_t             state_reg;
    status_t            status_reg;
    logic [ADDR_W-1:0]  idx_reg;
    logic [LEN_W-1:0]   cnt_reg;
    logic               last_reg;
    logic [7:0]         rd_data_reg;
    logic [7:0]         store_mem [BUFFER_BYTES];

    logic               out_take;

    always_ff @(posedge clk)
    begin
        if (store_wr.en)
        begin
            store_mem[store_wr.addr] <= store_wr.data;
        end
        rd_data_reg <= store_mem[idx_reg];
    end

    assign job_pop  = (state_reg == IDLE) && job_valid;
    assign out_take = out_ch.valid && out_ch.ready;

    assign replay_done = out_take && last_reg && (status_reg == ST_GOOD);

    assign out_ch.valid      = state_reg == SEND;
    assign out_ch.status     = status_reg;
    assign out_ch.data_byte  = (status_reg == ST_GOOD) ? rd_data_reg : 8'd0;
    assign out_ch.byte_index = (status_reg == ST_GOOD) ? 6'(idx_reg) : 6'd0;
    assign out_ch.last       = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            status_reg <= ST_GOOD;
            idx_reg    <= '0;
            cnt_reg    <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                IDLE:
                begin
                    if (job_valid)
                    begin
                        status_reg <= job.status;
                        cnt_reg    <= job.count;
                        idx_reg    <= '0;
                        if (job.status == ST_GOOD)
                        begin
                            state_reg <= READ;
                        end
                        else
                        begin
                            last_reg  <= 1'b1;
                            state_reg <= SEND;
                        end
                    end
                end
                READ:
                begin
                    last_reg  <= ({1'b0, idx_reg} + LEN_W'(1)) == cnt_reg;
                    state_reg <= SEND;
                end
                SEND:
                begin
                    if (out_take)
                    begin
                        if (last_reg)
                        begin
                            state_reg <= IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + ADDR_W'(1);
                            state_reg <= READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[design/slcfr_checker.sv]
// Port-level checks on the frame receiver output, bound to the top level
`default_nettype none
module slcfr_checker
    import slcfr_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  out_status,
    input wire logic [7:0]  out_data_byte,
    input wire logic [5:0]  out_byte_index,
    input wire logic        out_last
);

    logic out_take;

    assign out_take = out_valid && out_ready;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status != ST_GOOD |->
            out_data_byte == 8'd0 && out_byte_index == 6'd0 && out_last)
    else $error("error word must be a single zero word");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(out_status) && $stable(out_data_byte)
            && $stable(out_byte_index) && $stable(out_last))
    else $error("stalled output word changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_take && out_status == ST_GOOD && !out_last |=>
            !out_valid ##1 (out_valid && out_status == ST_GOOD
            && out_byte_index == $past(out_byte_index, 2) + 6'd1))
    else $error("replay index did not advance by one");

endmodule

bind sync_length_checksum_frame_receiver slcfr_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_status     (out_ch.status),
    .out_data_byte  (out_ch.data_byte),
    .out_byte_index (out_ch.byte_index),
    .out_last       (out_ch.last)
);
`default_nettype wire
